// ===== hdl/averaging_hysteresis_thermostat_macros.svh =====
// Assertion macros for the averaging hysteresis thermostat.
// Used by the top level; expects clk and rst_n in scope.
`ifndef AVERAGING_HYSTERESIS_THERMOSTAT_MACROS_SVH
`define AVERAGING_HYSTERESIS_THERMOSTAT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thermostat assertion failed");

// Next-cycle implication, checked out of reset.
`define AHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thermostat assertion failed");

`endif

// ===== hdl/aht_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the averaging hysteresis thermostat.
// No dependencies.
package aht_pkg;

  localparam int TEMP_W     = 8;
  localparam int WINDOW_DEF = 10;

  localparam int SETPOINT_W = 8;
  localparam int BAND_W     = 7;
  localparam int BLINK_W    = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SETPOINT_W-1:0] SETPOINT_RST = SETPOINT_W'(60);
  localparam logic [BAND_W-1:0]     BAND_RST     = BAND_W'(5);
  localparam logic [BLINK_W-1:0]    BLINK_RST    = BLINK_W'(19);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_CMP
  } state_t;

  // Commands from the sequencer to the averaging unit
  typedef struct packed {
    logic rd;   // read ring entry at current index
    logic upd;  // write sample, update running sum, advance index
    logic div;  // divide running sum by window
  } avg_ctrl_t;

endpackage

// ===== hdl/aht_avg.sv =====
`timescale 1ns / 1ps
// Sample ring memory, running sum and reciprocal divider.
// Depends on aht_pkg.
module aht_avg #(
  parameter int WINDOW = aht_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  aht_pkg::avg_ctrl_t          ctrl,
  input  logic [aht_pkg::TEMP_W-1:0]  sample,
  output logic [aht_pkg::TEMP_W-1:0]  mean
);

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SUM_W  = aht_pkg::TEMP_W + LOG_W;
  localparam int SHIFT  = SUM_W + LOG_W;
  localparam int RECIP_I = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [SHIFT:0] RECIP = (SHIFT+1)'(RECIP_I);
  localparam int PROD_W = SUM_W + SHIFT + 1;

  logic [aht_pkg::TEMP_W-1:0] ring_mem [WINDOW];
  logic [aht_pkg::TEMP_W-1:0] rdata_r;
  logic [WINDOW-1:0]          valid_r;
  logic                       old_valid_r;
  logic [IDX_W-1:0]           idx_r;
  logic [SUM_W-1:0]           sum_r;
  logic [aht_pkg::TEMP_W-1:0] quot_r;

  logic [SUM_W-1:0]  old_ext;
  logic [SUM_W-1:0]  sum_nxt;
  logic [IDX_W-1:0]  idx_nxt;
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rdata_r <= ring_mem[idx_r];
    end
    if (ctrl.upd) begin
      ring_mem[idx_r] <= sample;
    end
  end

  // An entry never written since reset reads as zero
  assign old_ext = old_valid_r ? SUM_W'(rdata_r) : '0;
  assign sum_nxt = sum_r - old_ext + SUM_W'(sample);
  assign idx_nxt = (idx_r == IDX_W'(WINDOW - 1)) ? '0 : idx_r + 1'b1;
  // Exact quotient for every sum below 2**SUM_W
  assign prod    = PROD_W'(sum_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      old_valid_r <= 1'b0;
      idx_r       <= '0;
      sum_r       <= '0;
    end else begin
      if (ctrl.rd) begin
        old_valid_r <= valid_r[idx_r];
      end
      if (ctrl.upd) begin
        valid_r[idx_r] <= 1'b1;
        idx_r          <= idx_nxt;
        sum_r          <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div) begin
      quot_r <= prod[SHIFT +: aht_pkg::TEMP_W];
    end
  end

  assign mean = quot_r;

endmodule

// ===== hdl/averaging_hysteresis_thermostat.sv =====
`timescale 1ns / 1ps
// Averaging bang-bang thermostat with deadband: top level.
// Depends on aht_pkg, aht_avg and averaging_hysteresis_thermostat_macros.svh.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_sys_on, in_sample
//   out      out_valid/out_ready  out_heater_on, out_cooler_on, out_led_on, out_average_temp
//   cfg      cfg_we               cfg_index, cfg_data
//
// A tick that stores its sample passes from transfer to the next possible transfer
// through ring memory read, sum update, reciprocal multiply and compare.
// Other ticks go straight to compare. One tick is in flight at a time.
// Reset is synchronous; ring entries read as zero until written (valid bits).
// A stalled result holds; the next tick may transfer in but waits to commit.
module averaging_hysteresis_thermostat #(
  parameter int WINDOW = aht_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_sys_on,
  input  logic [aht_pkg::TEMP_W-1:0]    in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_heater_on,
  output logic                          out_cooler_on,
  output logic                          out_led_on,
  output logic [aht_pkg::TEMP_W-1:0]    out_average_temp,
  input  logic                          cfg_we,
  input  logic [aht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aht_pkg::SETPOINT_W-1:0] cfg_data
);

  aht_pkg::state_t state_r, state_nxt;
  aht_pkg::avg_ctrl_t avg_ctrl;

  logic [aht_pkg::SETPOINT_W-1:0] setpoint_r;
  logic [aht_pkg::BAND_W-1:0]     band_r;
  logic [aht_pkg::BLINK_W-1:0]    blink_period_r;

  logic                       on_r;
  logic [aht_pkg::TEMP_W-1:0] sample_r;
  logic                       phase_r, phase_nxt;
  logic [aht_pkg::BLINK_W-1:0] blink_r, blink_nxt;
  logic                       heater_r, heater_nxt;
  logic                       cooler_r, cooler_nxt;
  logic                       led_r, led_nxt;
  logic [aht_pkg::TEMP_W-1:0] mean_r, mean_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic                       accept;
  logic                       commit;
  logic                       store;
  logic [aht_pkg::TEMP_W-1:0] avg_mean;
  logic [aht_pkg::TEMP_W:0]   upper;
  logic                       above;
  logic                       below;

  aht_avg #(.WINDOW(WINDOW)) u_avg (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (avg_ctrl),
    .sample (sample_r),
    .mean   (avg_mean)
  );

  assign accept = in_valid && in_ready;
  assign store  = on_r && !phase_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aht_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_sys_on && !phase_r) ? aht_pkg::ST_READ : aht_pkg::ST_CMP;
        end
      end
      aht_pkg::ST_READ: state_nxt = aht_pkg::ST_DIV;
      aht_pkg::ST_DIV:  state_nxt = aht_pkg::ST_CMP;
      aht_pkg::ST_CMP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = aht_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aht_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    avg_ctrl = '0;
    unique case (state_r)
      aht_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        avg_ctrl.rd = in_valid && in_sys_on && !phase_r;
      end
      aht_pkg::ST_READ: avg_ctrl.upd = 1'b1;
      aht_pkg::ST_DIV:  avg_ctrl.div = 1'b1;
      aht_pkg::ST_CMP:  commit = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Control law, applied at commit
  always_comb begin
    mean_nxt   = store ? avg_mean : mean_r;
    upper      = {1'b0, setpoint_r} + {2'b00, band_r};
    above      = {1'b0, mean_nxt} > upper;
    below      = ({1'b0, mean_nxt} + {2'b00, band_r}) < {1'b0, setpoint_r};
    phase_nxt  = phase_r;
    blink_nxt  = blink_r;
    heater_nxt = heater_r;
    cooler_nxt = cooler_r;
    led_nxt    = led_r;
    if (!on_r) begin
      mean_nxt   = mean_r;
      phase_nxt  = 1'b0;
      blink_nxt  = '0;
      heater_nxt = 1'b0;
      cooler_nxt = 1'b0;
      led_nxt    = 1'b0;
    end else begin
      phase_nxt = !phase_r;
      priority if (above) begin
        heater_nxt = 1'b0;
        cooler_nxt = 1'b1;
        led_nxt    = 1'b1;
      end else if (below) begin
        heater_nxt = 1'b1;
        cooler_nxt = 1'b0;
        if (blink_r < blink_period_r) begin
          blink_nxt = blink_r + 1'b1;
        end else begin
          blink_nxt = '0;
          led_nxt   = !led_r;
        end
      end else begin
        // inside the deadband: hold
      end
    end
  end

  assign out_valid_nxt = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= aht_pkg::ST_IDLE;
      setpoint_r     <= aht_pkg::SETPOINT_RST;
      band_r         <= aht_pkg::BAND_RST;
      blink_period_r <= aht_pkg::BLINK_RST;
      phase_r        <= 1'b0;
      blink_r        <= '0;
      heater_r       <= 1'b0;
      cooler_r       <= 1'b0;
      led_r          <= 1'b0;
      mean_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          aht_pkg::REG_SETPOINT:     setpoint_r     <= cfg_data;
          aht_pkg::REG_BAND:         band_r         <= cfg_data[aht_pkg::BAND_W-1:0];
          aht_pkg::REG_BLINK_PERIOD: blink_period_r <= cfg_data[aht_pkg::BLINK_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        phase_r  <= phase_nxt;
        blink_r  <= blink_nxt;
        heater_r <= heater_nxt;
        cooler_r <= cooler_nxt;
        led_r    <= led_nxt;
        mean_r   <= mean_nxt;
      end
    end
  end

  // Capture the tick on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      on_r     <= in_sys_on;
      sample_r <= in_sample;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_heater_on    = heater_r;
  assign out_cooler_on    = cooler_r;
  assign out_led_on       = led_r;
  assign out_average_temp = mean_r;

`include "averaging_hysteresis_thermostat_macros.svh"

  `AHT_ASSERT_NOW(a_drive_exclusive, 1'b1, !(heater_r && cooler_r))
  `AHT_ASSERT_NEXT(a_one_tick_in_flight, accept, !in_ready)
  `AHT_ASSERT_NEXT(a_off_drives_low, commit && !on_r, !heater_r && !cooler_r && !led_r)
  `AHT_ASSERT_NOW(a_commit_has_slot, commit, !out_valid_r || out_ready)

endmodule

// ===== verif/averaging_hysteresis_thermostat_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the averaging hysteresis thermostat: a scoreboard class predicts
// every result tick, plain tasks drive the input channel and the register port.
// Depends on aht_pkg and the averaging_hysteresis_thermostat top level.

typedef struct packed {
  logic       heater;
  logic       cooler;
  logic       led;
  logic [7:0] avg;
} thermo_out_t;

class thermo_scoreboard;
  logic [aht_pkg::SETPOINT_W-1:0] setpoint;
  logic [aht_pkg::BAND_W-1:0]     band;
  logic [aht_pkg::BLINK_W-1:0]    blink_period;

  logic [aht_pkg::TEMP_W-1:0] ring [aht_pkg::WINDOW_DEF];
  logic [3:0]                 ring_ptr;
  logic                       odd_tick;
  logic [aht_pkg::TEMP_W-1:0] mean;
  logic [aht_pkg::BLINK_W-1:0] blink_count;
  logic                       heater;
  logic                       cooler;
  logic                       led;

  thermo_out_t expected_q[$];
  int unsigned checked;
  int unsigned mismatches;
  int unsigned strays;
  int unsigned reported;

  function new();
    clear();
    checked    = 0;
    mismatches = 0;
    strays     = 0;
    reported   = 0;
  endfunction

  function void clear();
    setpoint     = aht_pkg::SETPOINT_RST;
    band         = aht_pkg::BAND_RST;
    blink_period = aht_pkg::BLINK_RST;
    foreach (ring[i]) ring[i] = '0;
    ring_ptr    = '0;
    odd_tick    = 1'b0;
    mean        = '0;
    blink_count = '0;
    heater      = 1'b0;
    cooler      = 1'b0;
    led         = 1'b0;
  endfunction

  function void write_reg(logic [aht_pkg::CFG_IDX_W-1:0] idx,
                          logic [aht_pkg::SETPOINT_W-1:0] data);
    case (idx)
      aht_pkg::REG_SETPOINT:     setpoint     = data;
      aht_pkg::REG_BAND:         band         = data[aht_pkg::BAND_W-1:0];
      aht_pkg::REG_BLINK_PERIOD: blink_period = data[aht_pkg::BLINK_W-1:0];
      default: ;
    endcase
  endfunction

  function void predict_tick(logic on, logic [aht_pkg::TEMP_W-1:0] sample);
    int sum;
    int upper;
    int lower;
    thermo_out_t res;
    if (!on) begin
      heater      = 1'b0;
      cooler      = 1'b0;
      led         = 1'b0;
      odd_tick    = 1'b0;
      blink_count = '0;
    end else begin
      // Store on alternate on ticks, then recompute the truncated mean.
      if (!odd_tick) begin
        ring[ring_ptr] = sample;
        ring_ptr = (ring_ptr == 4'(aht_pkg::WINDOW_DEF - 1)) ? 4'd0 : ring_ptr + 4'd1;
        sum = 0;
        for (int i = 0; i < aht_pkg::WINDOW_DEF; i++) sum += int'(ring[i]);
        mean = 8'(sum / aht_pkg::WINDOW_DEF);
        odd_tick = 1'b1;
      end else begin
        odd_tick = 1'b0;
      end
      // Signed thresholds: the lower one may go negative, the upper one never wraps.
      upper = int'(setpoint) + int'(band);
      lower = int'(setpoint) - int'(band);
      if (int'(mean) > upper) begin
        heater = 1'b0;
        cooler = 1'b1;
        led    = 1'b1;
      end else if (int'(mean) < lower) begin
        heater = 1'b1;
        cooler = 1'b0;
        if (blink_count < blink_period) begin
          blink_count = blink_count + 5'd1;
        end else begin
          blink_count = '0;
          led = ~led;
        end
      end
    end
    res.heater = heater;
    res.cooler = cooler;
    res.led    = led;
    res.avg    = mean;
    expected_q.push_back(res);
  endfunction

  function void check_outputs(logic h, logic c, logic l, logic [aht_pkg::TEMP_W-1:0] avg);
    thermo_out_t want;
    if (expected_q.size() == 0) begin
      strays++;
      if (reported < 10)
        $display("%0t: result with nothing pending: heater %0b cooler %0b led %0b avg %0d",
                 $time, h, c, l, avg);
      reported++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (want.heater !== h || want.cooler !== c || want.led !== l || want.avg !== avg) begin
      mismatches++;
      if (reported < 10)
        $display("%0t: mismatch: expected heater %0b cooler %0b led %0b avg %0d, got %0b %0b %0b %0d",
                 $time, want.heater, want.cooler, want.led, want.avg, h, c, l, avg);
      reported++;
    end
  endfunction

  function int unsigned pending_count();
    return expected_q.size();
  endfunction

  function int unsigned failures();
    return mismatches + strays + expected_q.size();
  endfunction
endclass

module averaging_hysteresis_thermostat_tb;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_sys_on = 1'b0;
  logic [aht_pkg::TEMP_W-1:0]     in_sample = '0;
  logic                           out_ready = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [aht_pkg::CFG_IDX_W-1:0]  cfg_index = aht_pkg::REG_SETPOINT;
  logic [aht_pkg::SETPOINT_W-1:0] cfg_data  = '0;

  logic                       in_ready;
  logic                       out_valid;
  logic                       out_heater_on;
  logic                       out_cooler_on;
  logic                       out_led_on;
  logic [aht_pkg::TEMP_W-1:0] out_average_temp;

  logic quiet      = 1'b0;
  int   stall_left = 0;

  int unsigned ticks_sent  = 0;
  int unsigned regs_written = 0;
  int unsigned phases_run  = 0;

  thermo_scoreboard sb;

  averaging_hysteresis_thermostat dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sys_on        (in_sys_on),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_heater_on    (out_heater_on),
    .out_cooler_on    (out_cooler_on),
    .out_led_on       (out_led_on),
    .out_average_temp (out_average_temp),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure: random stall bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (sb != null && rst_n) begin
      if (in_valid && in_ready) sb.predict_tick(in_sys_on, in_sample);
      if (out_valid && out_ready)
        sb.check_outputs(out_heater_on, out_cooler_on, out_led_on, out_average_temp);
    end
  end

  function automatic logic [7:0] clamp_temp(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  task automatic send_tick(logic on, logic [aht_pkg::TEMP_W-1:0] sample);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sys_on <= on;
    in_sample <= sample;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic send_run(logic on, logic [aht_pkg::TEMP_W-1:0] sample, int n);
    repeat (n) send_tick(on, sample);
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [aht_pkg::CFG_IDX_W-1:0] idx,
                           logic [aht_pkg::SETPOINT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    regs_written++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config();
    int unsigned pick;
    logic [7:0] sp;
    logic [6:0] bw;
    logic [4:0] bp;
    pick = $urandom_range(0, 4);
    sp = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 4);
    bw = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : 7'($urandom_range(0, 40));
    pick = $urandom_range(0, 4);
    bp = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : 5'($urandom_range(0, 31));
    // Random upper bits on the narrow registers must be dropped by the block.
    write_reg(aht_pkg::REG_SETPOINT, sp);
    write_reg(aht_pkg::REG_BAND, {1'($urandom_range(0, 1)), bw});
    write_reg(aht_pkg::REG_BLINK_PERIOD, {3'($urandom_range(0, 7)), bp});
    if ($urandom_range(0, 3) == 0)
      write_reg(aht_pkg::CFG_IDX_W'(3), 8'($urandom_range(0, 255)));
  endtask

  // Temperatures wander around a target near the setpoint so the mean crosses both edges.
  task automatic run_phase(int n_items);
    int target;
    logic on;
    logic [7:0] s;
    target = 0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 12 == 0)
        target = int'(sb.setpoint) + $urandom_range(0, 100) - 50;
      on = ($urandom_range(0, 15) != 0);
      if ($urandom_range(0, 9) == 0)
        s = 8'($urandom_range(0, 255));
      else
        s = clamp_temp(target + $urandom_range(0, 16) - 8);
      send_tick(on, s);
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: off tick, then a cold start with the mean climbing from zero.
    send_tick(1'b0, 8'd255);
    send_run(1'b1, 8'd255, 6);
    send_tick(1'b0, 8'd0);
    send_run(1'b1, 8'd0, 2);
    settle();

    // High setpoint, widest band, blink period zero; index 3 must be ignored.
    write_reg(aht_pkg::CFG_IDX_W'(3), 8'hFF);
    write_reg(aht_pkg::REG_SETPOINT, 8'd255);
    write_reg(aht_pkg::REG_BAND, 8'hFF);
    write_reg(aht_pkg::REG_BLINK_PERIOD, 8'hE0);
    send_run(1'b1, 8'd255, 5);
    send_tick(1'b1, 8'd0);
    settle();

    // Low setpoint: the lower threshold goes negative, so heating never starts.
    write_reg(aht_pkg::REG_SETPOINT, 8'd0);
    write_reg(aht_pkg::REG_BAND, 8'h7F);
    write_reg(aht_pkg::REG_BLINK_PERIOD, 8'hFF);
    send_run(1'b1, 8'd255, 6);
    send_run(1'b1, 8'd0, 2);
    settle();

    for (int p = 0; p < 17; p++) begin
      if (p == 15) quiet <= 1'b1;
      random_config();
      run_phase(60);
      settle();
      phases_run++;
    end

    $display("covered %0d ticks and %0d checked results over %0d random settings",
             ticks_sent, sb.checked, phases_run);
    $display("register writes: %0d, including extremes and ignored index", regs_written);
    if (sb.failures() == 0) begin
      $display("averaging_hysteresis_thermostat regression: pass");
    end else begin
      $display("%0d mismatches, %0d unexpected results, %0d missing", sb.mismatches,
               sb.strays, sb.pending_count());
      $display("averaging_hysteresis_thermostat regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results pending", sb.pending_count());
    $display("averaging_hysteresis_thermostat regression: fail");
    $finish;
  end

endmodule
